// ===== hdl/bfnc_pkg.sv =====
package bfnc_pkg;

   // field widths fixed by the port list
   localparam int NODE_FIELD_BITS   = 5;
   localparam int COUNT_FIELD_BITS  = 6;
   localparam int WEIGHT_FIELD_BITS = 16;
   localparam int DIST_FIELD_BITS   = 32;
   localparam int CSR_DATA_BITS     = 32;
   localparam int CSR_ADDR_BITS     = 3;

   // parameter defaults
   localparam int MAX_NODES_DEF   = 32;
   localparam int WEIGHT_BITS_DEF = 16;
   localparam int DIST_BITS_DEF   = 32;

   // no run reports more nodes than this
   localparam int RESULT_LIMIT = 32;

   // register reset values
   localparam logic [COUNT_FIELD_BITS-1:0] NODE_COUNT_RST  = 6'd8;
   localparam logic [NODE_FIELD_BITS-1:0]  SOURCE_NODE_RST = 5'd0;

   // register indexes (paddr[2])
   localparam logic CSR_NODE_COUNT  = 1'b0;
   localparam logic CSR_SOURCE_NODE = 1'b1;

   // request codes
   localparam logic [1:0] REQ_LOAD  = 2'd0;
   localparam logic [1:0] REQ_RUN   = 2'd1;
   localparam logic [1:0] REQ_CLEAR = 2'd2;

endpackage

// ===== hdl/bellman_ford_negative_cycle_top.sv =====
// Bellman-Ford shortest paths with negative-cycle detection.
// Request channel: a transaction is taken at a clock edge with start high and
// busy low. req_type selects load edge, run, or clear all edges; code 3 is a
// no-op. A load writes one adjacency entry (busy stays low).
// A clear sweeps the edge memory, one entry a cycle. The same sweep runs right
// after reset, with busy high throughout.
// A run with n nodes in use visits the edges of every reached row on each pass;
// each edge visit is a memory read plus one pass through the shared
// add/saturate/compare unit.
// Result channel: a run emits n transactions in node order, each shown for
// exactly one cycle with rsp_valid high; rsp_last marks the final one. The
// receiver cannot stall; results are never held.
// Configuration: APB-style, node_count at byte 0, source_node at byte 4. The user
// must keep them written only while busy is low and no result is pending; the
// block itself leaves this unchecked.
module bellman_ford_negative_cycle_top
   import bfnc_pkg::*;
#(
   parameter int MAX_NODES   = MAX_NODES_DEF,
   parameter int WEIGHT_BITS = WEIGHT_BITS_DEF,
   parameter int DIST_BITS   = DIST_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                start,
   output logic                                busy,
   input  logic [1:0]                          req_type,
   input  logic [NODE_FIELD_BITS-1:0]          req_from_node,
   input  logic [NODE_FIELD_BITS-1:0]          req_to_node,
   input  logic signed [WEIGHT_FIELD_BITS-1:0] req_edge_weight,
   // result channel
   output logic                                rsp_valid,
   output logic [NODE_FIELD_BITS-1:0]          rsp_node_index,
   output logic signed [DIST_FIELD_BITS-1:0]   rsp_distance,
   output logic [NODE_FIELD_BITS-1:0]          rsp_predecessor,
   output logic                                rsp_reachable,
   output logic                                rsp_still_improvable,
   output logic                                rsp_any_negative_cycle,
   output logic                                rsp_last,
   // configuration port
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [CSR_ADDR_BITS-1:0]            paddr,
   input  logic [CSR_DATA_BITS-1:0]            pwdata,
   output logic [CSR_DATA_BITS-1:0]            prdata,
   output logic                                pready
);

   localparam int NIW   = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int AW    = 2 * NIW;
   localparam int EDEPTH = 1 << AW;
   localparam int LIM   = (MAX_NODES < RESULT_LIMIT) ? MAX_NODES : RESULT_LIMIT;
   localparam int SW    = ((DIST_BITS > WEIGHT_BITS) ? DIST_BITS : WEIGHT_BITS) + 1;
   localparam logic signed [SW-1:0] DMAX = SW'((64'sd1 <<< (DIST_BITS - 1)) - 64'sd1);
   localparam logic signed [SW-1:0] DMIN = -DMAX - SW'(1);
   localparam int EW    = WEIGHT_BITS + 1;
   localparam int DW    = NIW + DIST_BITS;

   localparam logic [2:0] ST_SWEEP    = 3'd0;
   localparam logic [2:0] ST_IDLE     = 3'd1;
   localparam logic [2:0] ST_INIT     = 3'd2;
   localparam logic [2:0] ST_ROW      = 3'd3;
   localparam logic [2:0] ST_FETCH    = 3'd4;
   localparam logic [2:0] ST_EVAL     = 3'd5;
   localparam logic [2:0] ST_EMIT_RD  = 3'd6;
   localparam logic [2:0] ST_EMIT_OUT = 3'd7;

   // memories: edge entry is {present, weight}, node entry is {pred, dist}
   logic [EW-1:0] edge_mem [EDEPTH];
   logic [DW-1:0] node_mem [MAX_NODES];

   logic [2:0]                   state_ff, state_in;
   logic [COUNT_FIELD_BITS-1:0]  node_count_ff, node_count_in;
   logic [NODE_FIELD_BITS-1:0]   source_node_ff, source_node_in;
   logic [AW-1:0]                sweep_ff, sweep_in;
   logic [NIW-1:0]               i_ff, i_in;
   logic [NIW-1:0]               j_ff, j_in;
   logic [NIW-1:0]               pass_ff, pass_in;
   logic [NIW-1:0]               nm1_ff, nm1_in;
   logic                         check_ff, check_in;
   logic                         first_ff, first_in;
   logic                         any_ff, any_in;
   logic [MAX_NODES-1:0]         reach_ff, reach_in;
   logic [MAX_NODES-1:0]         improve_ff, improve_in;
   logic signed [DIST_BITS-1:0]  dist_i_ff, dist_i_in;
   logic [EW-1:0]                edge_rd_ff;
   logic [DW-1:0]                node_rd_ff;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [NODE_FIELD_BITS-1:0]   rsp_node_ff, rsp_node_in;
   logic signed [DIST_FIELD_BITS-1:0] rsp_dist_ff, rsp_dist_in;
   logic [NODE_FIELD_BITS-1:0]   rsp_pred_ff, rsp_pred_in;
   logic                         rsp_reach_ff, rsp_reach_in;
   logic                         rsp_impr_ff, rsp_impr_in;
   logic                         rsp_any_ff, rsp_any_in;
   logic                         rsp_last_ff, rsp_last_in;

   // memory port controls
   logic                         edge_we;
   logic [AW-1:0]                edge_wa, edge_ra;
   logic [EW-1:0]                edge_wd;
   logic                         node_we;
   logic [NIW-1:0]               node_wa, node_ra;
   logic [DW-1:0]                node_wd;

   // datapath
   logic [COUNT_FIELD_BITS-1:0]  n_eff;
   logic                         src_ok;
   logic                         from_ok, to_ok;
   logic signed [WEIGHT_BITS-1:0] w_load;
   logic signed [WEIGHT_BITS-1:0] w_edge;
   logic                         e_present;
   logic signed [DIST_BITS-1:0]  dist_j;
   logic signed [SW-1:0]         sum;
   logic signed [DIST_BITS-1:0]  cand;
   logic                         relax;
   logic                         csr_wr;

   assign csr_wr = psel & penable & pwrite & pready;
   assign pready = 1'b1;
   assign busy   = (state_ff != ST_IDLE);

   always_comb begin
      prdata = '0;
      unique case (paddr[2])
         CSR_NODE_COUNT:  prdata = CSR_DATA_BITS'(node_count_ff);
         CSR_SOURCE_NODE: prdata = CSR_DATA_BITS'(source_node_ff);
         default:         prdata = '0;
      endcase
   end

   always_comb begin
      if (node_count_ff == '0) begin
         n_eff = COUNT_FIELD_BITS'(1);
      end else if (node_count_ff > COUNT_FIELD_BITS'(LIM)) begin
         n_eff = COUNT_FIELD_BITS'(LIM);
      end else begin
         n_eff = node_count_ff;
      end
   end

   assign src_ok  = (COUNT_FIELD_BITS'(source_node_ff) < n_eff);
   assign from_ok = (int'(req_from_node) < MAX_NODES);
   assign to_ok   = (int'(req_to_node) < MAX_NODES);
   assign w_load  = WEIGHT_BITS'(req_edge_weight);

   // shared relax unit: saturated add and compare
   assign e_present = edge_rd_ff[EW-1];
   assign w_edge    = edge_rd_ff[WEIGHT_BITS-1:0];
   assign dist_j    = node_rd_ff[DIST_BITS-1:0];
   assign sum       = SW'(dist_i_ff) + SW'(w_edge);

   always_comb begin
      if (sum > DMAX) begin
         cand = DIST_BITS'(DMAX);
      end else if (sum < DMIN) begin
         cand = DIST_BITS'(DMIN);
      end else begin
         cand = DIST_BITS'(sum);
      end
   end

   assign relax = e_present & (~reach_ff[j_ff] | (cand < dist_j));

   always_comb begin
      state_in       = state_ff;
      node_count_in  = node_count_ff;
      source_node_in = source_node_ff;
      sweep_in       = sweep_ff;
      i_in           = i_ff;
      j_in           = j_ff;
      pass_in        = pass_ff;
      nm1_in         = nm1_ff;
      check_in       = check_ff;
      first_in       = first_ff;
      any_in         = any_ff;
      reach_in       = reach_ff;
      improve_in     = improve_ff;
      dist_i_in      = dist_i_ff;
      rsp_valid_in   = 1'b0;
      rsp_node_in    = rsp_node_ff;
      rsp_dist_in    = rsp_dist_ff;
      rsp_pred_in    = rsp_pred_ff;
      rsp_reach_in   = rsp_reach_ff;
      rsp_impr_in    = rsp_impr_ff;
      rsp_any_in     = rsp_any_ff;
      rsp_last_in    = rsp_last_ff;
      edge_we        = 1'b0;
      edge_wa        = sweep_ff;
      edge_wd        = '0;
      edge_ra        = {i_ff, j_ff};
      node_we        = 1'b0;
      node_wa        = j_ff;
      node_wd        = {i_ff, cand};
      node_ra        = j_ff;

      if (csr_wr) begin
         unique case (paddr[2])
            CSR_NODE_COUNT:  node_count_in  = pwdata[COUNT_FIELD_BITS-1:0];
            CSR_SOURCE_NODE: source_node_in = pwdata[NODE_FIELD_BITS-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_SWEEP: begin
            edge_we  = 1'b1;
            edge_wa  = sweep_ff;
            edge_wd  = '0;
            sweep_in = sweep_ff + AW'(1);
            if (sweep_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               unique case (req_type)
                  REQ_LOAD: begin
                     edge_we = from_ok & to_ok;
                     edge_wa = {NIW'(req_from_node), NIW'(req_to_node)};
                     edge_wd = {1'b1, w_load};
                  end
                  REQ_RUN: begin
                     nm1_in   = NIW'(n_eff - COUNT_FIELD_BITS'(1));
                     state_in = ST_INIT;
                  end
                  REQ_CLEAR: begin
                     sweep_in = '0;
                     state_in = ST_SWEEP;
                  end
                  default: ;
               endcase
            end
         end
         ST_INIT: begin
            reach_in   = '0;
            improve_in = '0;
            any_in     = 1'b0;
            if (src_ok) begin
               reach_in[NIW'(source_node_ff)] = 1'b1;
               node_we = 1'b1;
               node_wa = NIW'(source_node_ff);
               node_wd = {NIW'(source_node_ff), DIST_BITS'(0)};
            end
            i_in     = '0;
            pass_in  = '0;
            check_in = (nm1_ff == '0);
            state_in = ST_ROW;
         end
         ST_ROW, ST_EVAL: begin
            logic row_done;
            row_done = 1'b0;
            if (state_ff == ST_ROW) begin
               if (reach_ff[i_ff]) begin
                  node_ra  = i_ff;
                  j_in     = '0;
                  first_in = 1'b1;
                  state_in = ST_FETCH;
               end else begin
                  row_done = 1'b1;
               end
            end else begin
               if (relax) begin
                  if (check_ff) begin
                     improve_in[j_ff] = 1'b1;
                     any_in           = 1'b1;
                  end else begin
                     node_we        = 1'b1;
                     node_wa        = j_ff;
                     node_wd        = {i_ff, cand};
                     reach_in[j_ff] = 1'b1;
                     // self loop: the row's own distance moves too
                     if (j_ff == i_ff) begin
                        dist_i_in = cand;
                     end
                  end
               end
               if (j_ff == nm1_ff) begin
                  row_done = 1'b1;
               end else begin
                  j_in     = j_ff + NIW'(1);
                  state_in = ST_FETCH;
               end
            end
            if (row_done) begin
               if (i_ff == nm1_ff) begin
                  i_in = '0;
                  if (check_ff) begin
                     state_in = ST_EMIT_RD;
                  end else begin
                     pass_in  = pass_ff + NIW'(1);
                     check_in = ((pass_ff + NIW'(1)) == nm1_ff);
                     state_in = ST_ROW;
                  end
               end else begin
                  i_in     = i_ff + NIW'(1);
                  state_in = ST_ROW;
               end
            end
         end
         ST_FETCH: begin
            if (first_ff) begin
               dist_i_in = node_rd_ff[DIST_BITS-1:0];
            end
            first_in = 1'b0;
            edge_ra  = {i_ff, j_ff};
            node_ra  = j_ff;
            state_in = ST_EVAL;
         end
         ST_EMIT_RD: begin
            node_ra  = i_ff;
            state_in = ST_EMIT_OUT;
         end
         ST_EMIT_OUT: begin
            rsp_valid_in = 1'b1;
            rsp_node_in  = NODE_FIELD_BITS'(i_ff);
            rsp_reach_in = reach_ff[i_ff];
            rsp_impr_in  = improve_ff[i_ff];
            rsp_any_in   = any_ff;
            rsp_last_in  = (i_ff == nm1_ff);
            if (reach_ff[i_ff]) begin
               rsp_dist_in = DIST_FIELD_BITS'(dist_j);
               rsp_pred_in = NODE_FIELD_BITS'(node_rd_ff[DW-1:DIST_BITS]);
            end else begin
               rsp_dist_in = '0;
               rsp_pred_in = '0;
            end
            if (i_ff == nm1_ff) begin
               state_in = ST_IDLE;
            end else begin
               i_in     = i_ff + NIW'(1);
               state_in = ST_EMIT_RD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (edge_we) begin
         edge_mem[edge_wa] <= edge_wd;
      end
      edge_rd_ff <= edge_mem[edge_ra];
   end

   always_ff @(posedge clock) begin
      if (node_we) begin
         node_mem[node_wa] <= node_wd;
      end
      node_rd_ff <= node_mem[node_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_SWEEP;
         node_count_ff  <= NODE_COUNT_RST;
         source_node_ff <= SOURCE_NODE_RST;
         sweep_ff       <= '0;
         i_ff           <= '0;
         j_ff           <= '0;
         pass_ff        <= '0;
         nm1_ff         <= '0;
         check_ff       <= 1'b0;
         first_ff       <= 1'b0;
         any_ff         <= 1'b0;
         reach_ff       <= '0;
         improve_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         node_count_ff  <= node_count_in;
         source_node_ff <= source_node_in;
         sweep_ff       <= sweep_in;
         i_ff           <= i_in;
         j_ff           <= j_in;
         pass_ff        <= pass_in;
         nm1_ff         <= nm1_in;
         check_ff       <= check_in;
         first_ff       <= first_in;
         any_ff         <= any_in;
         reach_ff       <= reach_in;
         improve_ff     <= improve_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dist_i_ff    <= dist_i_in;
      rsp_node_ff  <= rsp_node_in;
      rsp_dist_ff  <= rsp_dist_in;
      rsp_pred_ff  <= rsp_pred_in;
      rsp_reach_ff <= rsp_reach_in;
      rsp_impr_ff  <= rsp_impr_in;
      rsp_any_ff   <= rsp_any_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_node_index         = rsp_node_ff;
   assign rsp_distance           = rsp_dist_ff;
   assign rsp_predecessor        = rsp_pred_ff;
   assign rsp_reachable          = rsp_reach_ff;
   assign rsp_still_improvable   = rsp_impr_ff;
   assign rsp_any_negative_cycle = rsp_any_ff;
   assign rsp_last               = rsp_last_ff;

endmodule

// ===== verif/bellman_ford_negative_cycle_top_tb.sv =====
`timescale 1ns / 1ps

module bellman_ford_negative_cycle_top_tb;
   import bfnc_pkg::*;

   // code 3 has no meaning in the block; it must be dropped silently
   localparam logic [1:0] REQ_NOOP = 2'd3;
   localparam int TARGET_ITEMS = 370;

   typedef struct {
      logic [NODE_FIELD_BITS-1:0]        node_index;
      logic signed [DIST_FIELD_BITS-1:0] distance;
      logic [NODE_FIELD_BITS-1:0]        predecessor;
      logic                              reachable;
      logic                              still_improvable;
      logic                              any_negative_cycle;
      logic                              last;
   } node_report_type;

   class bf_scoreboard;
      longint       weight_mem [MAX_NODES_DEF*MAX_NODES_DEF];
      bit           edge_mem [MAX_NODES_DEF*MAX_NODES_DEF];
      int unsigned  node_count_reg = 32'(NODE_COUNT_RST);
      int unsigned  source_reg = 32'(SOURCE_NODE_RST);
      node_report_type expected_reports[$];
      int           fail_count = 0;

      function void write_reg(logic idx, logic [CSR_DATA_BITS-1:0] value);
         if (idx == CSR_NODE_COUNT) begin
            node_count_reg = 32'(value[COUNT_FIELD_BITS-1:0]);
         end else begin
            source_reg = 32'(value[NODE_FIELD_BITS-1:0]);
         end
      endfunction

      function int outstanding();
         return expected_reports.size();
      endfunction

      function longint clip_dist(longint v);
         longint hi;
         longint lo;
         hi = (longint'(1) <<< (DIST_BITS_DEF - 1)) - 1;
         lo = -hi - 1;
         if (v > hi) return hi;
         if (v < lo) return lo;
         return v;
      endfunction

      // full Bellman-Ford run plus the check pass; queues one report per node
      function void solve_paths();
         int           n;
         int           i;
         int           j;
         int           pass;
         longint       path_dist [MAX_NODES_DEF];
         int           pred [MAX_NODES_DEF];
         bit           reached [MAX_NODES_DEF];
         bit           improv [MAX_NODES_DEF];
         bit           neg;
         longint       cand;
         node_report_type rep;
         n = int'(node_count_reg);
         if (n < 1) n = 1;
         if (n > MAX_NODES_DEF) n = MAX_NODES_DEF;
         if (n > RESULT_LIMIT) n = RESULT_LIMIT;
         neg = 0;
         for (i = 0; i < MAX_NODES_DEF; i++) begin
            path_dist[i] = 0;
            pred[i] = 0;
            reached[i] = 0;
            improv[i] = 0;
         end
         if (int'(source_reg) < n) begin
            reached[source_reg] = 1;
            pred[source_reg] = int'(source_reg);
         end
         for (pass = 0; pass + 1 < n; pass++) begin
            for (i = 0; i < n; i++) begin
               if (!reached[i]) continue;
               for (j = 0; j < n; j++) begin
                  if (!edge_mem[i*MAX_NODES_DEF+j]) continue;
                  cand = clip_dist(path_dist[i] + weight_mem[i*MAX_NODES_DEF+j]);
                  if (!reached[j] || cand < path_dist[j]) begin
                     path_dist[j] = cand;
                     pred[j] = i;
                     reached[j] = 1;
                  end
               end
            end
         end
         for (i = 0; i < n; i++) begin
            if (!reached[i]) continue;
            for (j = 0; j < n; j++) begin
               if (!edge_mem[i*MAX_NODES_DEF+j]) continue;
               cand = clip_dist(path_dist[i] + weight_mem[i*MAX_NODES_DEF+j]);
               if (!reached[j] || cand < path_dist[j]) begin
                  improv[j] = 1;
                  neg = 1;
               end
            end
         end
         for (i = 0; i < n; i++) begin
            rep.node_index = NODE_FIELD_BITS'(i);
            rep.distance = reached[i] ? path_dist[i][DIST_FIELD_BITS-1:0] : '0;
            rep.predecessor = reached[i] ? NODE_FIELD_BITS'(pred[i]) : '0;
            rep.reachable = reached[i];
            rep.still_improvable = improv[i];
            rep.any_negative_cycle = neg;
            rep.last = (i + 1 == n);
            expected_reports.push_back(rep);
         end
      endfunction

      function void note_request(logic [1:0] kind, logic [NODE_FIELD_BITS-1:0] from_n,
                                 logic [NODE_FIELD_BITS-1:0] to_n,
                                 logic signed [WEIGHT_FIELD_BITS-1:0] weight);
         case (kind)
            REQ_LOAD: begin
               weight_mem[from_n*MAX_NODES_DEF+to_n] = longint'(weight);
               edge_mem[from_n*MAX_NODES_DEF+to_n] = 1;
            end
            REQ_CLEAR: begin
               foreach (edge_mem[k]) edge_mem[k] = 0;
            end
            REQ_RUN: solve_paths();
            default: ;
         endcase
      endfunction

      function void check_result(node_report_type got);
         node_report_type want;
         if (expected_reports.size() == 0) begin
            $error("unexpected result transaction for node %0d", got.node_index);
            fail_count++;
            return;
         end
         want = expected_reports.pop_front();
         if (got.node_index !== want.node_index) begin
            $error("node_index mismatch: expected %0d, got %0d", want.node_index,
                   got.node_index);
            fail_count++;
         end
         if (got.distance !== want.distance) begin
            $error("distance mismatch: expected %0d, got %0d", want.distance, got.distance);
            fail_count++;
         end
         if (got.predecessor !== want.predecessor) begin
            $error("predecessor mismatch: expected %0d, got %0d", want.predecessor,
                   got.predecessor);
            fail_count++;
         end
         if (got.reachable !== want.reachable) begin
            $error("reachable mismatch: expected %0d, got %0d", want.reachable,
                   got.reachable);
            fail_count++;
         end
         if (got.still_improvable !== want.still_improvable) begin
            $error("still_improvable mismatch: expected %0d, got %0d",
                   want.still_improvable, got.still_improvable);
            fail_count++;
         end
         if (got.any_negative_cycle !== want.any_negative_cycle) begin
            $error("any_negative_cycle mismatch: expected %0d, got %0d",
                   want.any_negative_cycle, got.any_negative_cycle);
            fail_count++;
         end
         if (got.last !== want.last) begin
            $error("last mismatch: expected %0d, got %0d", want.last, got.last);
            fail_count++;
         end
      endfunction
   endclass

   logic                                clock;
   logic                                reset;
   logic                                start;
   logic                                busy;
   logic [1:0]                          req_type;
   logic [NODE_FIELD_BITS-1:0]          req_from_node;
   logic [NODE_FIELD_BITS-1:0]          req_to_node;
   logic signed [WEIGHT_FIELD_BITS-1:0] req_edge_weight;
   logic                                rsp_valid;
   logic [NODE_FIELD_BITS-1:0]          rsp_node_index;
   logic signed [DIST_FIELD_BITS-1:0]   rsp_distance;
   logic [NODE_FIELD_BITS-1:0]          rsp_predecessor;
   logic                                rsp_reachable;
   logic                                rsp_still_improvable;
   logic                                rsp_any_negative_cycle;
   logic                                rsp_last;
   logic                                psel;
   logic                                penable;
   logic                                pwrite;
   logic [CSR_ADDR_BITS-1:0]            paddr;
   logic [CSR_DATA_BITS-1:0]            pwdata;
   logic [CSR_DATA_BITS-1:0]            prdata;
   logic                                pready;

   bf_scoreboard sb = new;
   node_report_type seen_report;
   int           sent_count = 0;
   int           active_nodes = int'(NODE_COUNT_RST);
   int           active_source = int'(SOURCE_NODE_RST);

   bellman_ford_negative_cycle_top uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_type(req_type),
      .req_from_node(req_from_node),
      .req_to_node(req_to_node),
      .req_edge_weight(req_edge_weight),
      .rsp_valid(rsp_valid),
      .rsp_node_index(rsp_node_index),
      .rsp_distance(rsp_distance),
      .rsp_predecessor(rsp_predecessor),
      .rsp_reachable(rsp_reachable),
      .rsp_still_improvable(rsp_still_improvable),
      .rsp_any_negative_cycle(rsp_any_negative_cycle),
      .rsp_last(rsp_last),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #400_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         seen_report.node_index = rsp_node_index;
         seen_report.distance = rsp_distance;
         seen_report.predecessor = rsp_predecessor;
         seen_report.reachable = rsp_reachable;
         seen_report.still_improvable = rsp_still_improvable;
         seen_report.any_negative_cycle = rsp_any_negative_cycle;
         seen_report.last = rsp_last;
         sb.check_result(seen_report);
      end
   end

   function automatic int pick_gap(bit burst);
      int r;
      if (burst) return 0;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 60);
   endfunction

   function automatic logic signed [WEIGHT_FIELD_BITS-1:0] pick_weight();
      int r;
      r = $urandom_range(0, 9);
      if (r < 6) return WEIGHT_FIELD_BITS'(int'($urandom_range(0, 230)) - 30);
      if (r < 9) return WEIGHT_FIELD_BITS'($urandom_range(0, 65535));
      return ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
   endfunction

   function automatic logic [NODE_FIELD_BITS-1:0] pick_node(bit tail);
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return NODE_FIELD_BITS'($urandom_range(0, 31));
      if (tail && r < 3) return NODE_FIELD_BITS'(active_source);
      return NODE_FIELD_BITS'($urandom_range(0, active_nodes - 1));
   endfunction

   // holds start until the transaction is taken, then idles for the given gap
   task automatic send_item(input logic [1:0] kind, input logic [NODE_FIELD_BITS-1:0] from_n,
                            input logic [NODE_FIELD_BITS-1:0] to_n,
                            input logic signed [WEIGHT_FIELD_BITS-1:0] weight,
                            input int gap);
      @(negedge clock);
      start <= 1'b1;
      req_type <= kind;
      req_from_node <= from_n;
      req_to_node <= to_n;
      req_edge_weight <= weight;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_request(kind, from_n, to_n, weight);
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic send_other(input logic [1:0] kind, input int gap);
      send_item(kind, NODE_FIELD_BITS'($urandom_range(0, 31)),
                NODE_FIELD_BITS'($urandom_range(0, 31)),
                WEIGHT_FIELD_BITS'($urandom_range(0, 65535)), gap);
   endtask

   task automatic load_edge(input int from_n, input int to_n, input int weight);
      send_item(REQ_LOAD, NODE_FIELD_BITS'(from_n), NODE_FIELD_BITS'(to_n),
                WEIGHT_FIELD_BITS'(weight), pick_gap(1'b0));
   endtask

   // drop start, then wait for all results and for the block to go idle
   task automatic wait_idle();
      int guard;
      guard = 0;
      @(negedge clock);
      start <= 1'b0;
      @(posedge clock);
      while ((sb.outstanding() != 0 || busy) && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(input logic idx, input logic [CSR_DATA_BITS-1:0] value);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      sb.write_reg(idx, value);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic apply_setting(input int count, input int src);
      wait_idle();
      // upper data bits carry junk; only the field bits should land
      csr_write(CSR_NODE_COUNT, ($urandom() & 32'hffff_ffc0) | count);
      csr_write(CSR_SOURCE_NODE, ($urandom() & 32'hffff_ffe0) | src);
      active_nodes = (count == 0) ? 1 : ((count > MAX_NODES_DEF) ? MAX_NODES_DEF : count);
      active_source = src;
   endtask

   task automatic run_phase(input int sequences);
      int s;
      int k;
      int loads;
      int cap;
      bit burst;
      for (s = 0; s < sequences; s++) begin
         burst = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 6) == 0) begin
            send_other(REQ_CLEAR, pick_gap(burst));
            sent_count++;
         end
         cap = (3 * active_nodes < 20) ? 3 * active_nodes : 20;
         loads = $urandom_range(0, cap);
         for (k = 0; k < loads; k++) begin
            if ($urandom_range(0, 19) == 0) send_other(REQ_NOOP, pick_gap(burst));
            send_item(REQ_LOAD, pick_node(1'b1), pick_node(1'b0), pick_weight(),
                      pick_gap(burst));
            sent_count++;
         end
         // now and then a sequence is left without its run
         if ($urandom_range(0, 9) != 0) begin
            send_other(REQ_RUN, pick_gap(burst));
            sent_count++;
         end
      end
   endtask

   initial begin
      int count;
      int src;
      reset = 1'b1;
      start = 1'b0;
      req_type = REQ_LOAD;
      req_from_node = '0;
      req_to_node = '0;
      req_edge_weight = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // directed: weight extremes, overwrite, unused node, unreachable negative loop,
      // reachable negative cycle, clear, self loop, zero-weight cycle, ignored code
      load_edge(0, 1, 32767);
      load_edge(1, 2, -32768);
      load_edge(2, 3, 0);
      load_edge(31, 31, -1);
      load_edge(0, 1, 5);
      load_edge(3, 1, 100);
      send_other(REQ_RUN, 0);
      send_other(REQ_NOOP, 1);
      load_edge(4, 5, 7);
      load_edge(5, 4, -20);
      send_other(REQ_RUN, 2);
      load_edge(2, 0, -10);
      send_other(REQ_RUN, 0);
      send_other(REQ_CLEAR, 3);
      send_other(REQ_RUN, 0);
      load_edge(0, 0, -1);
      send_other(REQ_RUN, 1);
      send_other(REQ_CLEAR, 0);
      load_edge(7, 0, 3);
      load_edge(0, 7, -3);
      send_other(REQ_RUN, 0);
      sent_count = 19;

      apply_setting(0, 0);
      run_phase(4);
      apply_setting(32, 31);
      run_phase(2);
      apply_setting(5, 9);
      run_phase(3);
      apply_setting(63, 0);
      run_phase(2);
      apply_setting(3, 2);
      run_phase(4);
      while (sent_count < TARGET_ITEMS) begin
         count = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 20) : $urandom_range(1, 9);
         src = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31)
                                             : $urandom_range(0, count - 1);
         apply_setting(count, src);
         run_phase((count >= 16) ? 2 : 4);
      end

      wait_idle();
      repeat (100) @(posedge clock);
      if (sb.outstanding() != 0) begin
         $error("%0d expected results never arrived", sb.outstanding());
         sb.fail_count++;
      end
      if (sb.fail_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
